// ===== hw/rtl/fsg_pkg.sv =====
package fsg_pkg;

    localparam int DigitW     = 6;
    localparam int IndexW     = 32;
    localparam int FracW      = 32;
    localparam int MaxDims    = 32;
    localparam int MaxDigits  = 32;
    localparam int SkipPower  = 4;
    localparam int PowW       = 24;   // holds 63^4
    localparam int AddrW      = 4;

    // register indexes (paddr[3:2])
    localparam logic [1:0] RegBase  = 2'd0;
    localparam logic [1:0] RegDims  = 2'd1;
    localparam logic [1:0] RegStart = 2'd2;

    typedef struct packed {
        logic [DigitW-1:0] prime_base;
        logic [DigitW-1:0] dimension_count;
        logic [IndexW-1:0] start_index;
        logic              restart;      // pulse: base or start written
    } cfg_t;

endpackage

// ===== hw/rtl/faure_sequence_generator_top.sv =====
// Faure point generator. Each request transaction with request=1 yields
// dimension_count (clamped to 1..32) coordinate transactions (last one
// flagged by m_tlast); a request of 0 is taken and produces nothing.
// Each point splits the index into base-b digits by serial division;
// each dimension after the first applies the Pascal transform, and every
// dimension then runs the bit-serial radical inverse. The first request
// after reset or after a write to prime_base or start_index passes
// through SKIP_MUL and LOAD to load the counter with start_index + b^4 - 1.
// s_tready is high only between points.
module faure_sequence_generator_top (
    input  logic        aclk,
    input  logic        aresetn,
    // request input, tdata[0] = request
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // coordinate output, tdata[31:0] = coordinate, [36:32] = dimension_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fsg_pkg::*;

    typedef enum logic [3:0] {
        IDLE, SKIP_MUL, LOAD, DIGIT, DIV_WAIT, SHIFT, RI, EMIT
    } state_t;

    cfg_t cfg;
    state_t state_reg;

    logic [IndexW-1:0] seq_reg;
    logic              started_reg;
    logic [DigitW-1:0] base_reg;
    logic [DigitW-1:0] dims_reg;
    logic [PowW-1:0]   pow_reg;
    logic [1:0]        mul_cnt_reg;
    logic [IndexW-1:0] n_reg;
    logic [5:0]        t_reg;
    logic [DigitW-1:0] digits [MaxDigits];
    logic [DigitW-1:0] tmp    [MaxDigits];
    logic [DigitW-1:0] top_reg;
    logic [4:0]        i_reg;
    logic [4:0]        j_reg;
    logic [DigitW-1:0] prev_reg;
    logic [4:0]        d_reg;
    logic [4:0]        bit_reg;
    logic [4:0]        k_reg;
    logic              carry_reg;
    logic [FracW-1:0]  r_reg;
    logic              m_tvalid_reg;
    logic [FracW-1:0]  m_coord_reg;
    logic [4:0]        m_dim_reg;
    logic              m_last_reg;

    logic              div_start;
    logic              div_done;
    logic [IndexW-1:0] div_q;
    logic [DigitW-1:0] div_rem;

    logic [DigitW:0]   sh_sum;
    logic [DigitW-1:0] sh_val;
    logic [DigitW-1:0] ri_src;
    logic [DigitW:0]   ri_dbl;
    logic              ri_c;
    logic [DigitW-1:0] ri_val;
    logic [DigitW-1:0] eff_base;
    logic [DigitW-1:0] eff_dims;
    logic [PowW+DigitW-1:0] pow_prod;
    logic              out_free;

    fsg_cfg_regs u_cfg (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg
    );

    fsg_div_unit u_div (
        .aclk, .aresetn,
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (base_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_rem)
    );

    assign eff_base = (cfg.prime_base < DigitW'(2)) ? DigitW'(2) : cfg.prime_base;
    always_comb begin
        if (cfg.dimension_count == '0)
            eff_dims = DigitW'(1);
        else if (cfg.dimension_count > DigitW'(MaxDims))
            eff_dims = DigitW'(MaxDims);
        else
            eff_dims = cfg.dimension_count;
    end

    assign pow_prod  = pow_reg * base_reg;
    assign div_start = (state_reg == DIGIT) && (n_reg != '0) && (t_reg != 6'(MaxDigits));

    // Pascal step: a[j] += a[j+1] mod b
    assign sh_sum = {1'b0, digits[j_reg]} + {1'b0, prev_reg};
    assign sh_val = (sh_sum >= {1'b0, base_reg}) ? DigitW'(sh_sum - {1'b0, base_reg})
                                                : sh_sum[DigitW-1:0];

    // radical inverse step: double digit with carry mod b
    assign ri_src = (bit_reg == '0) ? digits[k_reg] : tmp[k_reg];
    assign ri_dbl = {ri_src, carry_reg};
    assign ri_c   = ri_dbl >= {1'b0, base_reg};
    assign ri_val = ri_c ? DigitW'(ri_dbl - {1'b0, base_reg}) : ri_dbl[DigitW-1:0];

    assign out_free = !m_tvalid_reg || m_tready;

    // digit stores
    always_ff @(posedge aclk) begin
        if (state_reg == DIV_WAIT && div_done)
            digits[t_reg[4:0]] <= div_rem;
        else if (state_reg == SHIFT)
            digits[j_reg] <= sh_val;
        if (state_reg == RI)
            tmp[k_reg] <= ri_val;
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            started_reg  <= 1'b0;
            seq_reg      <= IndexW'(15);
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (cfg.restart)
                started_reg <= 1'b0;
            unique case (state_reg)
                IDLE: begin
                    if (s_tvalid && s_tdata[0]) begin
                        base_reg <= eff_base;
                        dims_reg <= eff_dims;
                        pow_reg  <= PowW'(eff_base);
                        mul_cnt_reg <= '0;
                        n_reg    <= seq_reg;
                        t_reg    <= '0;
                        d_reg    <= '0;
                        state_reg <= (started_reg && !cfg.restart) ? DIGIT : SKIP_MUL;
                    end
                end
                SKIP_MUL: begin
                    pow_reg     <= pow_prod[PowW-1:0];
                    mul_cnt_reg <= mul_cnt_reg + 2'd1;
                    if (mul_cnt_reg == 2'(SkipPower-2))
                        state_reg <= LOAD;
                end
                LOAD: begin
                    seq_reg     <= cfg.start_index + IndexW'(pow_reg) - IndexW'(1);
                    n_reg       <= cfg.start_index + IndexW'(pow_reg) - IndexW'(1);
                    started_reg <= 1'b1;
                    state_reg   <= DIGIT;
                end
                DIGIT: begin
                    if (div_start) begin
                        state_reg <= DIV_WAIT;
                    end else begin
                        bit_reg   <= '0;
                        k_reg     <= 5'(t_reg - 6'd1);
                        carry_reg <= 1'b0;
                        r_reg     <= '0;
                        state_reg <= (t_reg == '0) ? EMIT : RI;
                    end
                end
                DIV_WAIT: begin
                    if (div_done) begin
                        top_reg   <= div_rem;
                        n_reg     <= div_q;
                        t_reg     <= t_reg + 6'd1;
                        state_reg <= DIGIT;
                    end
                end
                SHIFT: begin
                    prev_reg <= sh_val;
                    if (j_reg == i_reg) begin
                        if (6'(i_reg) + 6'd2 == t_reg) begin
                            bit_reg   <= '0;
                            k_reg     <= 5'(t_reg - 6'd1);
                            carry_reg <= 1'b0;
                            r_reg     <= '0;
                            state_reg <= RI;
                        end else begin
                            i_reg    <= i_reg + 5'd1;
                            j_reg    <= 5'(t_reg - 6'd2);
                            prev_reg <= top_reg;
                        end
                    end else begin
                        j_reg <= j_reg - 5'd1;
                    end
                end
                RI: begin
                    if (k_reg == '0) begin
                        r_reg     <= {r_reg[FracW-2:0], ri_c};
                        carry_reg <= 1'b0;
                        k_reg     <= 5'(t_reg - 6'd1);
                        bit_reg   <= bit_reg + 5'd1;
                        if (bit_reg == 5'(FracW-1))
                            state_reg <= EMIT;
                    end else begin
                        carry_reg <= ri_c;
                        k_reg     <= k_reg - 5'd1;
                    end
                end
                EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_coord_reg  <= r_reg;
                        m_dim_reg    <= d_reg;
                        m_last_reg   <= (6'(d_reg) + 6'd1 == dims_reg);
                        if (6'(d_reg) + 6'd1 == dims_reg) begin
                            seq_reg   <= seq_reg + IndexW'(1);
                            state_reg <= IDLE;
                        end else begin
                            d_reg <= d_reg + 5'd1;
                            if (t_reg <= 6'd1) begin
                                bit_reg   <= '0;
                                k_reg     <= 5'(t_reg - 6'd1);
                                carry_reg <= 1'b0;
                                r_reg     <= '0;
                                state_reg <= (t_reg == '0) ? EMIT : RI;
                            end else begin
                                i_reg     <= '0;
                                j_reg     <= 5'(t_reg - 6'd2);
                                prev_reg  <= top_reg;
                                state_reg <= SHIFT;
                            end
                        end
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_dim_reg, m_coord_reg};
    assign m_tlast  = m_last_reg;

    a_digits_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        t_reg <= 6'(MaxDigits) || state_reg == IDLE)
        else $error("digit count overflow");
    a_base_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SHIFT || state_reg == RI) |-> base_reg >= DigitW'(2))
        else $error("working base below two");
    a_dim_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == EMIT) |-> 6'(d_reg) < dims_reg)
        else $error("dimension index beyond count");
    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == LOAD) |=> started_reg && state_reg == DIGIT)
        else $error("counter load did not start point");

endmodule

// ===== hw/rtl/fsg_cfg_regs.sv =====
module fsg_cfg_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [fsg_pkg::AddrW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output fsg_pkg::cfg_t             cfg
);
    import fsg_pkg::*;

    logic [DigitW-1:0] base_reg;
    logic [DigitW-1:0] dims_reg;
    logic [IndexW-1:0] start_reg;
    logic              restart_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= DigitW'(2);
            dims_reg    <= DigitW'(1);
            start_reg   <= '0;
            restart_reg <= 1'b0;
        end else begin
            restart_reg <= 1'b0;
            if (wr_en) begin
                unique case (paddr[3:2])
                    RegBase: begin
                        base_reg    <= pwdata[DigitW-1:0];
                        restart_reg <= 1'b1;
                    end
                    RegDims: dims_reg <= pwdata[DigitW-1:0];
                    RegStart: begin
                        start_reg   <= pwdata[IndexW-1:0];
                        restart_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // read mux
    always_comb begin
        unique case (paddr[3:2])
            RegBase:  prdata = {{(32-DigitW){1'b0}}, base_reg};
            RegDims:  prdata = {{(32-DigitW){1'b0}}, dims_reg};
            RegStart: prdata = start_reg;
            default:  prdata = '0;
        endcase
    end

    assign cfg.prime_base      = base_reg;
    assign cfg.dimension_count = dims_reg;
    assign cfg.start_index     = start_reg;
    assign cfg.restart         = restart_reg;

endmodule

// ===== hw/rtl/fsg_div_unit.sv =====
module fsg_div_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [fsg_pkg::IndexW-1:0] dividend,
    input  logic [fsg_pkg::DigitW-1:0] divisor,
    output logic                       done,
    output logic [fsg_pkg::IndexW-1:0] quotient,
    output logic [fsg_pkg::DigitW-1:0] remainder
);
    import fsg_pkg::*;

    logic [IndexW-1:0] q_reg;
    logic [DigitW-1:0] rem_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DigitW:0]   trial;
    logic              fits;

    // one restoring step per cycle
    assign trial = {rem_reg, q_reg[IndexW-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                q_reg    <= dividend;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= fits ? DigitW'(trial - {1'b0, divisor}) : trial[DigitW-1:0];
                q_reg   <= {q_reg[IndexW-2:0], fits};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(IndexW-1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule
